### rtl/sac_pkg.sv
// shared types and constants for the set-associative write-back cache
package sac_pkg;

    localparam int SET_BITS_MAX_DEF = 6;
    localparam int WAYS_MAX_DEF     = 8;
    localparam int BLOCK_BITS_LIMIT = 20;
    localparam int EFF_WAYS_W       = 6;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways;
        logic [4:0] block_bits;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [63:0] tag;
        logic [63:0] stamp;
    } line_t;

endpackage

### rtl/sac_if.sv
// request and response channel interfaces
interface sac_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink (input valid, input mode, input address, output ready);
endinterface

interface sac_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic        wrote_back;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
    logic [47:0] dirty_evicted_bytes;
    logic [29:0] dirty_bytes_in_cache;

    modport source (output valid, output outcome, output wrote_back, output hit_count,
                    output miss_count, output eviction_count, output dirty_evicted_bytes,
                    output dirty_bytes_in_cache, input ready);
    modport sink (input valid, input outcome, input wrote_back, input hit_count,
                  input miss_count, input eviction_count, input dirty_evicted_bytes,
                  input dirty_bytes_in_cache, output ready);
endinterface

### rtl/sac_ram.sv
// generic single-port-write, registered-read ram
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/sac_cfg.sv
// apb configuration registers
module sac_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output sac_pkg::cfg_t    cfg
);

    sac_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits   <= 3'd0;
            cfg_reg.ways       <= 4'd1;
            cfg_reg.block_bits <= 5'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                sac_pkg::REG_SET_BITS:   cfg_reg.set_bits   <= pwdata[2:0];
                sac_pkg::REG_WAYS:       cfg_reg.ways       <= pwdata[3:0];
                sac_pkg::REG_BLOCK_BITS: cfg_reg.block_bits <= pwdata[4:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            sac_pkg::REG_SET_BITS:   prdata = {29'd0, cfg_reg.set_bits};
            sac_pkg::REG_WAYS:       prdata = {28'd0, cfg_reg.ways};
            sac_pkg::REG_BLOCK_BITS: prdata = {27'd0, cfg_reg.block_bits};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

### rtl/set_assoc_lru_writeback_cache.sv
// Set-associative write-back, write-allocate cache model with exact LRU. Each access first
// reads its whole set (all ways, with tags, stamps, valid and dirty bits) from the set memory,
// then compares, picks the hit or victim way and writes the set back. A new request is taken
// only once the previous lookup is done; the response register lets the next access start while
// a result waits, though its lookup holds until that result is taken. No clearing pass is needed
// after reset: a per-set written flag makes untouched sets read as empty.
module set_assoc_lru_writeback_cache #(
    parameter int SET_BITS_MAX = sac_pkg::SET_BITS_MAX_DEF,
    parameter int WAYS_MAX     = sac_pkg::WAYS_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sac_req_if.sink     req,
    sac_rsp_if.source   rsp
);

    localparam int SET_IW = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int SETS   = 2 ** SET_IW;
    localparam int LINES  = (2 ** SET_BITS_MAX) * WAYS_MAX;
    localparam int WAY_IW = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
    localparam int ROW_W  = WAYS_MAX * $bits(sac_pkg::line_t);
    localparam int DC_W   = $clog2(LINES + 1);
    localparam int EW     = sac_pkg::EFF_WAYS_W;

    sac_pkg::cfg_t cfg;

    sac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective geometry
    logic [3:0]    s_eff;
    logic [4:0]    b_eff;
    logic [EW-1:0] e_eff;
    logic [6:0]    shift_amt;
    logic [63:0]   tag_in;
    logic [63:0]   addr_sh;
    logic [SET_IW-1:0] set_in;

    always_comb
    begin
        s_eff = (int'(cfg.set_bits) > SET_BITS_MAX) ? 4'(SET_BITS_MAX) : {1'b0, cfg.set_bits};
        b_eff = (int'(cfg.block_bits) > sac_pkg::BLOCK_BITS_LIMIT)
              ? 5'(sac_pkg::BLOCK_BITS_LIMIT) : cfg.block_bits;
        if (cfg.ways == 4'd0)
            e_eff = EW'(1);
        else if (int'(cfg.ways) > WAYS_MAX)
            e_eff = EW'(WAYS_MAX);
        else
            e_eff = EW'(cfg.ways);
        shift_amt = 7'(s_eff) + 7'(b_eff);
        tag_in    = (shift_amt >= 7'd64) ? 64'd0 : (req.address >> shift_amt);
        addr_sh   = req.address >> b_eff;
        set_in    = addr_sh[SET_IW-1:0] & ~({SET_IW{1'b1}} << s_eff);
    end

    sac_pkg::state_t   state_reg, state_next;
    logic              mode_reg;
    logic [SET_IW-1:0] set_reg;
    logic [63:0]       tag_reg;
    logic [SETS-1:0]   rv_reg;
    logic [63:0]       tick_reg;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       miss_reg, miss_next;
    logic [31:0]       evict_reg, evict_next;
    logic [47:0]       wbb_reg, wbb_next;
    logic [DC_W-1:0]   dc_reg, dc_next;
    sac_pkg::outcome_t outcome_reg, outcome_next;
    logic              wb_reg, wb_next;
    logic              out_valid_reg;

    logic              accept;
    logic              adv;
    logic              req_ready;

    logic [ROW_W-1:0]  rdata;
    sac_pkg::line_t [WAYS_MAX-1:0] row_rd, row_eff, row_new;

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk   (clk),
        .we    (adv),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (set_in),
        .rdata (rdata)
    );

    assign row_rd = rdata;

    // control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sac_pkg::ST_IDLE:   if (accept) state_next = sac_pkg::ST_LOOKUP;
            sac_pkg::ST_LOOKUP: if (adv)    state_next = sac_pkg::ST_IDLE;
            default:            state_next = sac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == sac_pkg::ST_IDLE);
        adv       = (state_reg == sac_pkg::ST_LOOKUP) && (!out_valid_reg || rsp.ready);
        accept    = req.valid && req_ready;
    end

    assign req.ready = req_ready;

    // lookup and victim choice
    logic [WAYS_MAX-1:0] in_use, hit_vec, inv_vec, lru_vec;
    logic                hit_any, inv_any;
    logic [WAY_IW-1:0]   hit_way, inv_way, lru_way, victim;
    logic                vdirty;
    logic [48:0]         wbb_sum;

    always_comb
    begin
        for (int i = 0; i < WAYS_MAX; i++)
        begin
            row_eff[i] = row_rd[i];
            if (!rv_reg[set_reg])
            begin
                row_eff[i].valid = 1'b0;
                row_eff[i].dirty = 1'b0;
            end
            in_use[i]  = EW'(i) < e_eff;
            hit_vec[i] = in_use[i] && row_eff[i].valid && (row_eff[i].tag == tag_reg);
            inv_vec[i] = in_use[i] && !row_eff[i].valid;
        end
        // oldest stamp, ties go to the lowest way
        for (int i = 0; i < WAYS_MAX; i++)
        begin
            lru_vec[i] = in_use[i];
            for (int j = 0; j < WAYS_MAX; j++)
            begin
                if (in_use[j] && j < i && !(row_eff[i].stamp < row_eff[j].stamp))
                    lru_vec[i] = 1'b0;
                if (in_use[j] && j > i && !(row_eff[i].stamp <= row_eff[j].stamp))
                    lru_vec[i] = 1'b0;
            end
        end
        hit_any = |hit_vec;
        inv_any = |inv_vec;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int i = WAYS_MAX - 1; i >= 0; i--)
        begin
            if (hit_vec[i]) hit_way = WAY_IW'(i);
            if (inv_vec[i]) inv_way = WAY_IW'(i);
            if (lru_vec[i]) lru_way = WAY_IW'(i);
        end
        victim = inv_any ? inv_way : lru_way;
        vdirty = row_eff[victim].dirty;

        row_new      = row_eff;
        hits_next    = hits_reg;
        miss_next    = miss_reg;
        evict_next   = evict_reg;
        wbb_next     = wbb_reg;
        dc_next      = dc_reg;
        outcome_next = sac_pkg::OUT_HIT;
        wb_next      = 1'b0;
        wbb_sum      = 49'(wbb_reg) + (49'd1 << b_eff);

        if (hit_any)
        begin
            hits_next = (hits_reg == '1) ? hits_reg : hits_reg + 32'd1;
            row_new[hit_way].stamp = tick_reg;
            if (mode_reg && !row_eff[hit_way].dirty)
            begin
                row_new[hit_way].dirty = 1'b1;
                dc_next = dc_reg + DC_W'(1);
            end
        end
        else
        begin
            miss_next = (miss_reg == '1) ? miss_reg : miss_reg + 32'd1;
            if (!inv_any)
            begin
                outcome_next = sac_pkg::OUT_EVICT;
                evict_next   = (evict_reg == '1) ? evict_reg : evict_reg + 32'd1;
                if (vdirty)
                begin
                    wb_next  = 1'b1;
                    wbb_next = wbb_sum[48] ? '1 : wbb_sum[47:0];
                end
            end
            else
            begin
                outcome_next = sac_pkg::OUT_FILL;
            end
            dc_next = dc_reg - DC_W'(vdirty) + DC_W'(mode_reg);
            row_new[victim].valid = 1'b1;
            row_new[victim].dirty = mode_reg;
            row_new[victim].tag   = tag_reg;
            row_new[victim].stamp = tick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sac_pkg::ST_IDLE;
            rv_reg        <= '0;
            tick_reg      <= 64'd1;
            hits_reg      <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
            wbb_reg       <= '0;
            dc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                rv_reg[set_reg] <= 1'b1;
                tick_reg        <= tick_reg + 64'd1;
                hits_reg        <= hits_next;
                miss_reg        <= miss_next;
                evict_reg       <= evict_next;
                wbb_reg         <= wbb_next;
                dc_reg          <= dc_next;
                out_valid_reg   <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            set_reg  <= set_in;
            tag_reg  <= tag_in;
        end
        if (adv)
        begin
            outcome_reg <= outcome_next;
            wb_reg      <= wb_next;
        end
    end

    logic [63:0] held_bytes;
    assign held_bytes = 64'(dc_reg) << b_eff;

    assign rsp.valid                = out_valid_reg;
    assign rsp.outcome              = outcome_reg;
    assign rsp.wrote_back           = wb_reg;
    assign rsp.hit_count            = hits_reg;
    assign rsp.miss_count           = miss_reg;
    assign rsp.eviction_count       = evict_reg;
    assign rsp.dirty_evicted_bytes  = wbb_reg;
    assign rsp.dirty_bytes_in_cache = held_bytes[29:0];

`ifndef SYNTHESIS
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == sac_pkg::ST_LOOKUP)
        else $error("accepted request did not start a lookup");

    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("finished lookup produced no result");

    a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(dc_reg) <= LINES)
        else $error("dirty line count exceeds line count");

    a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        adv && hit_any |=> outcome_reg == sac_pkg::OUT_HIT && !wb_reg)
        else $error("hit reported as miss or write-back");

    a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && wb_reg |-> outcome_reg == sac_pkg::OUT_EVICT)
        else $error("write-back without eviction");
`endif

endmodule

### verif/set_assoc_lru_writeback_cache_checker.sv
// checker: predicts cache results from observed transfers and compares them
`timescale 1ns / 1ps
module set_assoc_lru_writeback_cache_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        req_mode,
    input  logic [63:0] req_address,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  rsp_outcome,
    input  logic        rsp_wrote_back,
    input  logic [31:0] rsp_hit_count,
    input  logic [31:0] rsp_miss_count,
    input  logic [31:0] rsp_eviction_count,
    input  logic [47:0] rsp_dirty_evicted_bytes,
    input  logic [29:0] rsp_dirty_bytes_in_cache,
    output int          fail_count,
    output int          pending_count
);
    localparam int NLINES = (1 << sac_pkg::SET_BITS_MAX_DEF) * sac_pkg::WAYS_MAX_DEF;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        wrote_back;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
        logic [47:0] wb_bytes;
        logic [29:0] held_bytes;
    } access_result_t;

    sac_pkg::cfg_t cfg;
    bit          lv [NLINES];
    bit          ld [NLINES];
    bit [63:0]   ltag [NLINES];
    bit [63:0]   lstamp [NLINES];
    bit [63:0]   tick;
    bit [31:0]   hits, misses, evictions;
    bit [47:0]   wb_bytes;
    int unsigned dirty_cnt;
    access_result_t expected_results[$];

    function automatic bit [31:0] sat32(bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic access_result_t predict_access(bit store, bit [63:0] addr);
        access_result_t r;
        int s, e, b, base, victim;
        bit [63:0] set_idx, tag;
        bit found;
        s = (cfg.set_bits > sac_pkg::SET_BITS_MAX_DEF) ? sac_pkg::SET_BITS_MAX_DEF
                                                         : cfg.set_bits;
        e = (cfg.ways == 0) ? 1 : ((cfg.ways > sac_pkg::WAYS_MAX_DEF) ? sac_pkg::WAYS_MAX_DEF
                                                                       : cfg.ways);
        b = (cfg.block_bits > sac_pkg::BLOCK_BITS_LIMIT) ? sac_pkg::BLOCK_BITS_LIMIT
                                                          : cfg.block_bits;
        set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
        tag = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
        base = int'(set_idx) * sac_pkg::WAYS_MAX_DEF;
        found = 0;
        r = '0;
        for (int i = 0; i < e && !found; i++)
        begin
            if (lv[base+i] && ltag[base+i] == tag)
            begin
                hits = sat32(hits);
                lstamp[base+i] = tick;
                tick++;
                if (store && !ld[base+i])
                begin
                    ld[base+i] = 1;
                    dirty_cnt++;
                end
                found = 1;
            end
        end
        if (!found)
        begin
            misses = sat32(misses);
            victim = e;
            for (int i = e - 1; i >= 0; i--)
                if (!lv[base+i]) victim = i;
            if (victim == e)
            begin
                r.outcome = sac_pkg::OUT_EVICT;
                evictions = sat32(evictions);
                victim = 0;
                for (int i = 1; i < e; i++)
                    if (lstamp[base+i] < lstamp[base+victim]) victim = i;
                if (ld[base+victim])
                begin
                    r.wrote_back = 1;
                    if (48'hFFFF_FFFF_FFFF - wb_bytes < (48'd1 << b))
                        wb_bytes = 48'hFFFF_FFFF_FFFF;
                    else
                        wb_bytes = wb_bytes + (48'd1 << b);
                    ld[base+victim] = 0;
                    dirty_cnt--;
                end
            end
            else
            begin
                r.outcome = sac_pkg::OUT_FILL;
                if (ld[base+victim])
                begin
                    ld[base+victim] = 0;
                    dirty_cnt--;
                end
            end
            victim += base;
            lv[victim] = 1;
            ltag[victim] = tag;
            lstamp[victim] = tick;
            tick++;
            if (store)
            begin
                ld[victim] = 1;
                dirty_cnt++;
            end
        end
        r.hits = hits;
        r.misses = misses;
        r.evictions = evictions;
        r.wb_bytes = wb_bytes;
        r.held_bytes = 30'((64'(dirty_cnt) << b));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t exp_r, got;
        if (!rst_n)
        begin
            cfg = '{set_bits: 3'd0, ways: 4'd1, block_bits: 5'd0};
            for (int i = 0; i < NLINES; i++)
            begin
                lv[i] = 0;
                ld[i] = 0;
                ltag[i] = '0;
                lstamp[i] = '0;
            end
            tick = 64'd1;
            hits = '0;
            misses = '0;
            evictions = '0;
            wb_bytes = '0;
            dirty_cnt = 0;
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    sac_pkg::REG_SET_BITS:   cfg.set_bits = pwdata[2:0];
                    sac_pkg::REG_WAYS:       cfg.ways = pwdata[3:0];
                    sac_pkg::REG_BLOCK_BITS: cfg.block_bits = pwdata[4:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                got = '{rsp_outcome, rsp_wrote_back, rsp_hit_count, rsp_miss_count,
                        rsp_eviction_count, rsp_dirty_evicted_bytes,
                        rsp_dirty_bytes_in_cache};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got != exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            // request predicted after response check so a same-edge pair stays ordered
            if (req_valid && req_ready)
                expected_results.push_back(predict_access(req_mode, req_address));
            pending_count = expected_results.size();
        end
    end
endmodule

### verif/set_assoc_lru_writeback_cache_tb.sv
// testbench top: reset, register setup, access stimulus and verdict
`timescale 1ns / 1ps
module set_assoc_lru_writeback_cache_tb;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending_count;
    int          send_idle_pct, recv_idle_pct;
    int          quiet_cycles;
    bit          timed_out;
    bit [63:0]   recent_addr[$];

    sac_req_if req ();
    sac_rsp_if rsp ();

    set_assoc_lru_writeback_cache dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .rsp(rsp.source)
    );

    set_assoc_lru_writeback_cache_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .req_valid(req.valid), .req_ready(req.ready), .req_mode(req.mode),
        .req_address(req.address),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_outcome(rsp.outcome),
        .rsp_wrote_back(rsp.wrote_back), .rsp_hit_count(rsp.hit_count),
        .rsp_miss_count(rsp.miss_count), .rsp_eviction_count(rsp.eviction_count),
        .rsp_dirty_evicted_bytes(rsp.dirty_evicted_bytes),
        .rsp_dirty_bytes_in_cache(rsp.dirty_bytes_in_cache),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [31:0] sb, logic [31:0] w, logic [31:0] bb);
        write_reg(sac_pkg::REG_SET_BITS, sb);
        write_reg(sac_pkg::REG_WAYS, w);
        write_reg(sac_pkg::REG_BLOCK_BITS, bb);
    endtask

    task automatic send_access(bit store, bit [63:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.mode <= store;
        req.address <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        recent_addr.push_back(addr);
        if (recent_addr.size() > 24)
            void'(recent_addr.pop_front());
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly reuse of a small working set so hits, evictions and write-backs all occur
    task automatic random_accesses(int count);
        bit [63:0] a;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 55 && recent_addr.size() > 0)
                a = recent_addr[$urandom_range(recent_addr.size() - 1)] ^ 64'($urandom_range(3));
            else if (pick < 85)
                a = 64'($urandom_range(4095)) << $urandom_range(8);
            else
                a = rand64();
            send_access(1'($urandom_range(1)), a);
        end
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req.valid = 0;
        req.mode = 0;
        req.address = '0;
        rsp.ready = 0;
        send_idle_pct = 17;
        recv_idle_pct = 85;
        quiet_cycles = 0;
        timed_out = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset geometry, address extremes, loads and stores
        send_access(1'b0, 64'd0);
        send_access(1'b1, 64'd0);
        send_access(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(1'b1, 64'h8000_0000_0000_0000);
        send_access(1'b0, 64'd0);
        send_access(1'b1, 64'h5555_5555_5555_5555);
        send_access(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();
        // wide geometry: set plus block bits reach 64 only through clamping is impossible,
        // so cover clamping of out-of-range register values instead
        set_geometry(32'd7, 32'd0, 32'd31);
        send_access(1'b1, 64'h0000_0000_0010_0000);
        send_access(1'b1, 64'h0000_0000_0410_0000);
        send_access(1'b0, 64'h0000_0000_0010_0000);
        drain();
        set_geometry(32'd6, 32'd15, 32'd20);
        for (int i = 0; i < 10; i++)
            send_access(1'b1, {32'h0, 4'(i), 28'h0});
        send_access(1'b0, 64'h0);
        drain();
        // shrink ways: dirty lines outside the geometry still count
        set_geometry(32'd2, 32'd2, 32'd4);
        send_access(1'b0, 64'h100);
        send_access(1'b1, 64'h200);
        send_access(1'b0, 64'h300);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : ((phase == 1) ? 85 : 0);
            recv_idle_pct = (phase == 0) ? 85 : ((phase == 1) ? 17 : 0);
            for (int g = 0; g < 6; g++)
            begin
                set_geometry($urandom_range(7), $urandom_range(15), $urandom_range(31));
                random_accesses(73);
                drain();
            end
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
